>>> sv/assert_macros.svh
// Assertion macros used by the RTL file of the block lace parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> sv/mkvlace_pkg.sv
// Types and constants of the Matroska block lace parser.
package mkvlace_pkg;

    typedef enum logic [13:0] {
        ST_READY     = 14'b00000000000001,
        ST_DECODE    = 14'b00000000000010,
        ST_PTS       = 14'b00000000000100,
        ST_XIPH      = 14'b00000000001000,
        ST_DADD      = 14'b00000000010000,
        ST_DSUB      = 14'b00000000100000,
        ST_LSUM      = 14'b00000001000000,
        ST_OV1       = 14'b00000010000000,
        ST_OV2       = 14'b00000100000000,
        ST_EMIT_LACE = 14'b00001000000000,
        ST_EMIT_REST = 14'b00010000000000,
        ST_FSUB      = 14'b00100000000000,
        ST_DIV       = 14'b01000000000000,
        ST_EMIT_FIX  = 14'b10000000000000
    } seq_state_t;

    typedef enum logic [8:0] {
        PH_IDLE       = 9'b000000001,
        PH_TRACK      = 9'b000000010,
        PH_TC_HI      = 9'b000000100,
        PH_TC_LO      = 9'b000001000,
        PH_FLAGS      = 9'b000010000,
        PH_COUNT      = 9'b000100000,
        PH_XIPH       = 9'b001000000,
        PH_EBML_FIRST = 9'b010000000,
        PH_EBML_DELTA = 9'b100000000
    } phase_t;

    localparam logic [1:0] LACE_NONE  = 2'd0;
    localparam logic [1:0] LACE_XIPH  = 2'd1;
    localparam logic [1:0] LACE_FIXED = 2'd2;
    localparam logic [1:0] LACE_EBML  = 2'd3;

    localparam logic [7:0]  XIPH_RUN  = 8'hFF;
    localparam int          CAP_BIT   = 40;
    localparam logic [40:0] SUM_CAP   = 41'h100_0000_0000;
    localparam logic [15:0] HDR_MAX   = 16'hFFFF;
    localparam logic [31:0] SIZE_MAX  = 32'hFFFF_FFFF;

endpackage

>>> sv/matroska_block_lace_parser.sv
// Matroska block header parser that emits one record per coded lace size, a last record
// for the rest of the block, and a single record with a repeat count for fixed lacing.
// Header bytes are taken one request at a time. A plain header byte is accepted, then
// decoded; the timecode low byte also adds the timecode on the shared 64-bit adder.
// Each coded lace size takes the adder steps that apply to it (run or delta add, range
// subtract, running sum, two-step overrun check), then is loaded into the output register
// once that is free. Fixed lacing divides the remaining size by the frame count with a
// 32-step restoring division on the same adder (count byte accept, decode, start subtract, 32 steps, load).
// The output register holds a finished record while the next byte is taken.
`include "assert_macros.svh"

module matroska_block_lace_parser #(
    parameter int VINT_MAX_BYTES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               block_start,
    input  logic [31:0]        block_size,
    input  logic               is_simple,
    input  logic [47:0]        cluster_timecode,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [55:0]        track_number,
    output logic signed [49:0] pts,
    output logic               keyframe,
    output logic [31:0]        frame_size,
    output logic [8:0]         repeat_count,
    output logic [15:0]        header_size,
    output logic               last_lace,
    output logic               status
);

    localparam logic [3:0] VMAX = 4'(VINT_MAX_BYTES);

    mkvlace_pkg::seq_state_t state_reg, state_next;
    mkvlace_pkg::phase_t     phase_reg, phase_next;

    logic [7:0]  b_reg, b_next;
    logic [55:0] vacc_reg, vacc_next;
    logic [3:0]  vleft_reg, vleft_next;
    logic [3:0]  vlen_reg, vlen_next;
    logic [55:0] track_reg, track_next;
    logic [49:0] pts_reg, pts_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] bsize_reg, bsize_next;
    logic [7:0]  laces_reg, laces_next;
    logic [63:0] lacc_reg, lacc_next;
    logic [40:0] lsum_reg, lsum_next;
    logic [15:0] hcnt_reg, hcnt_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [63:0] lx_reg, lx_next;
    logic        neg_reg, neg_next;
    logic        lpath_reg, lpath_next;
    logic        over_reg, over_next;
    logic [31:0] rest_reg, rest_next;
    logic [8:0]  rep_reg, rep_next;
    logic [31:0] quot_reg, quot_next;
    logic [7:0]  rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        fbad_reg, fbad_next;

    logic        ov_reg, ov_next;
    logic [31:0] osize_reg, osize_next;
    logic [8:0]  orep_reg, orep_next;
    logic [15:0] ohdr_reg, ohdr_next;
    logic        olast_reg, olast_next;
    logic        ostat_reg, ostat_next;
    logic [55:0] otrack_reg, otrack_next;
    logic [49:0] opts_reg, opts_next;
    logic        okey_reg, okey_next;

    // Shared 64-bit adder.
    logic [63:0] alu_a, alu_b;
    logic        alu_cin;
    logic [64:0] alu_res;
    logic [63:0] alu_sum;
    logic        alu_cout;

    assign alu_res  = {1'b0, alu_a} + {1'b0, alu_b} + {64'd0, alu_cin};
    assign alu_sum  = alu_res[63:0];
    assign alu_cout = alu_res[64];

    logic        accept;
    logic        can_load;
    logic [15:0] tc;
    logic [5:0]  sh;
    logic [63:0] shift_mask;
    logic [3:0]  lz_len;
    logic [3:0]  v_len;
    logic [55:0] v_acc;
    logic [3:0]  v_left;
    logic        v_done;
    logic [7:0]  laces_dec;
    logic        x_cap;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != mkvlace_pkg::ST_READY);
    assign can_load = !ov_reg || !out_stall;
    assign tc       = {vacc_reg[7:0], b_reg};
    assign sh       = 6'(({2'b00, vlen_reg} * 6'd7) - 6'd1);
    assign shift_mask = ~({64{1'b1}} << sh);
    assign laces_dec  = laces_reg - 8'd1;
    assign x_cap      = |lx_reg[63:mkvlace_pkg::CAP_BIT];

    // Length of a variable-length integer from the position of its first set bit.
    always_comb
    begin
        lz_len = 4'd9;
        for (int i = 0; i < 8; i++)
        begin
            if (b_reg[i])
            begin
                lz_len = 4'(8 - i);
            end
        end
    end

    always_comb
    begin
        v_len  = vlen_reg;
        v_acc  = vacc_reg;
        v_left = vleft_reg;
        if (vleft_reg == 4'd0)
        begin
            if (lz_len > VMAX)
            begin
                v_len = VMAX;
                v_acc = '0;
            end
            else
            begin
                v_len = lz_len;
                v_acc = {48'd0, b_reg & (8'hFF >> lz_len)};
            end
            v_left = v_len - 4'd1;
        end
        else
        begin
            v_acc  = {vacc_reg[47:0], b_reg};
            v_left = vleft_reg - 4'd1;
        end
        v_done = (v_left == 4'd0);
    end

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (state_reg)
            mkvlace_pkg::ST_PTS:
            begin
                alu_a = {14'd0, pts_reg};
                alu_b = {{48{tc[15]}}, tc};
            end
            mkvlace_pkg::ST_XIPH:
            begin
                alu_a = lacc_reg;
                alu_b = {56'd0, b_reg};
            end
            mkvlace_pkg::ST_DADD:
            begin
                alu_a = lacc_reg;
                alu_b = {8'd0, vacc_reg};
            end
            mkvlace_pkg::ST_DSUB:
            begin
                alu_a   = tmp_reg;
                alu_b   = ~shift_mask;
                alu_cin = 1'b1;
            end
            mkvlace_pkg::ST_LSUM:
            begin
                alu_a = {23'd0, lsum_reg};
                alu_b = lx_reg;
            end
            mkvlace_pkg::ST_OV1:
            begin
                alu_a = {23'd0, lsum_reg};
                alu_b = {48'd0, hcnt_reg};
            end
            mkvlace_pkg::ST_OV2:
            begin
                alu_a   = {32'd0, bsize_reg};
                alu_b   = ~tmp_reg;
                alu_cin = 1'b1;
            end
            mkvlace_pkg::ST_FSUB:
            begin
                alu_a   = {32'd0, bsize_reg};
                alu_b   = ~{48'd0, hcnt_reg};
                alu_cin = 1'b1;
            end
            mkvlace_pkg::ST_DIV:
            begin
                alu_a   = {55'd0, rem_reg, quot_reg[31]};
                alu_b   = ~{55'd0, rep_reg};
                alu_cin = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        b_next     = b_reg;
        vacc_next  = vacc_reg;
        vleft_next = vleft_reg;
        vlen_next  = vlen_reg;
        track_next = track_reg;
        pts_next   = pts_reg;
        flags_next = flags_reg;
        bsize_next = bsize_reg;
        laces_next = laces_reg;
        lacc_next  = lacc_reg;
        lsum_next  = lsum_reg;
        hcnt_next  = hcnt_reg;
        tmp_next   = tmp_reg;
        lx_next    = lx_reg;
        neg_next   = neg_reg;
        lpath_next = lpath_reg;
        over_next  = over_reg;
        rest_next  = rest_reg;
        rep_next   = rep_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        fbad_next  = fbad_reg;

        ov_next     = ov_reg && out_stall;
        osize_next  = osize_reg;
        orep_next   = orep_reg;
        ohdr_next   = ohdr_reg;
        olast_next  = olast_reg;
        ostat_next  = ostat_reg;
        otrack_next = otrack_reg;
        opts_next   = opts_reg;
        okey_next   = okey_reg;

        unique case (state_reg)
            mkvlace_pkg::ST_READY:
            begin
                if (accept)
                begin
                    b_next = data_byte;
                    if (block_start)
                    begin
                        phase_next = mkvlace_pkg::PH_TRACK;
                        vacc_next  = '0;
                        vleft_next = '0;
                        vlen_next  = '0;
                        track_next = '0;
                        pts_next   = {2'b00, cluster_timecode};
                        flags_next = {is_simple, 7'd0};
                        bsize_next = block_size;
                        laces_next = '0;
                        lacc_next  = '0;
                        lsum_next  = '0;
                        hcnt_next  = 16'd1;
                        state_next = mkvlace_pkg::ST_DECODE;
                    end
                    else if (phase_reg != mkvlace_pkg::PH_IDLE)
                    begin
                        if (hcnt_reg != mkvlace_pkg::HDR_MAX)
                        begin
                            hcnt_next = hcnt_reg + 16'd1;
                        end
                        state_next = mkvlace_pkg::ST_DECODE;
                    end
                end
            end
            mkvlace_pkg::ST_DECODE:
            begin
                state_next = mkvlace_pkg::ST_READY;
                unique case (phase_reg)
                    mkvlace_pkg::PH_TRACK:
                    begin
                        vacc_next  = v_acc;
                        vleft_next = v_left;
                        vlen_next  = v_len;
                        if (v_done)
                        begin
                            track_next = v_acc;
                            phase_next = mkvlace_pkg::PH_TC_HI;
                        end
                    end
                    mkvlace_pkg::PH_TC_HI:
                    begin
                        vacc_next  = {48'd0, b_reg};
                        phase_next = mkvlace_pkg::PH_TC_LO;
                    end
                    mkvlace_pkg::PH_TC_LO:
                    begin
                        state_next = mkvlace_pkg::ST_PTS;
                    end
                    mkvlace_pkg::PH_FLAGS:
                    begin
                        flags_next = b_reg & {flags_reg[7], 7'h7F};
                        if (b_reg[2:1] == mkvlace_pkg::LACE_NONE)
                        begin
                            lpath_next = 1'b0;
                            state_next = mkvlace_pkg::ST_OV1;
                        end
                        else
                        begin
                            phase_next = mkvlace_pkg::PH_COUNT;
                        end
                    end
                    mkvlace_pkg::PH_COUNT:
                    begin
                        laces_next = b_reg;
                        lacc_next  = '0;
                        if (flags_reg[2:1] == mkvlace_pkg::LACE_FIXED)
                        begin
                            rep_next   = {1'b0, b_reg} + 9'd1;
                            state_next = mkvlace_pkg::ST_FSUB;
                        end
                        else if (b_reg == 8'd0)
                        begin
                            lpath_next = 1'b0;
                            state_next = mkvlace_pkg::ST_OV1;
                        end
                        else if (flags_reg[2:1] == mkvlace_pkg::LACE_XIPH)
                        begin
                            phase_next = mkvlace_pkg::PH_XIPH;
                        end
                        else
                        begin
                            phase_next = mkvlace_pkg::PH_EBML_FIRST;
                        end
                    end
                    mkvlace_pkg::PH_XIPH:
                    begin
                        state_next = mkvlace_pkg::ST_XIPH;
                    end
                    mkvlace_pkg::PH_EBML_FIRST:
                    begin
                        vacc_next  = v_acc;
                        vleft_next = v_left;
                        vlen_next  = v_len;
                        if (v_done)
                        begin
                            lacc_next  = {8'd0, v_acc};
                            lx_next    = {8'd0, v_acc};
                            neg_next   = 1'b0;
                            phase_next = mkvlace_pkg::PH_EBML_DELTA;
                            lpath_next = 1'b1;
                            state_next = mkvlace_pkg::ST_LSUM;
                        end
                    end
                    mkvlace_pkg::PH_EBML_DELTA:
                    begin
                        vacc_next  = v_acc;
                        vleft_next = v_left;
                        vlen_next  = v_len;
                        if (v_done)
                        begin
                            state_next = mkvlace_pkg::ST_DADD;
                        end
                    end
                    default:
                    begin
                        phase_next = mkvlace_pkg::PH_IDLE;
                    end
                endcase
            end
            mkvlace_pkg::ST_PTS:
            begin
                pts_next   = alu_sum[49:0];
                phase_next = mkvlace_pkg::PH_FLAGS;
                state_next = mkvlace_pkg::ST_READY;
            end
            mkvlace_pkg::ST_XIPH:
            begin
                // The run length saturates at the sum cap.
                if (|alu_sum[63:mkvlace_pkg::CAP_BIT])
                begin
                    lacc_next = {23'd0, mkvlace_pkg::SUM_CAP};
                end
                else
                begin
                    lacc_next = alu_sum;
                end
                if (b_reg != mkvlace_pkg::XIPH_RUN)
                begin
                    lx_next    = lacc_next;
                    lacc_next  = '0;
                    neg_next   = 1'b0;
                    lpath_next = 1'b1;
                    state_next = mkvlace_pkg::ST_LSUM;
                end
                else
                begin
                    state_next = mkvlace_pkg::ST_READY;
                end
            end
            mkvlace_pkg::ST_DADD:
            begin
                tmp_next   = alu_sum;
                state_next = mkvlace_pkg::ST_DSUB;
            end
            mkvlace_pkg::ST_DSUB:
            begin
                lacc_next  = alu_sum;
                lx_next    = alu_sum;
                neg_next   = alu_sum[63];
                lpath_next = 1'b1;
                state_next = mkvlace_pkg::ST_LSUM;
            end
            mkvlace_pkg::ST_LSUM:
            begin
                if (neg_reg || x_cap || (|alu_sum[63:mkvlace_pkg::CAP_BIT]))
                begin
                    lsum_next = mkvlace_pkg::SUM_CAP;
                end
                else
                begin
                    lsum_next = alu_sum[40:0];
                end
                state_next = mkvlace_pkg::ST_OV1;
            end
            mkvlace_pkg::ST_OV1:
            begin
                tmp_next   = alu_sum;
                state_next = mkvlace_pkg::ST_OV2;
            end
            mkvlace_pkg::ST_OV2:
            begin
                // A borrow out of the subtraction means the header and laces overrun.
                over_next  = !alu_cout;
                rest_next  = alu_sum[31:0];
                state_next = lpath_reg ? mkvlace_pkg::ST_EMIT_LACE
                                       : mkvlace_pkg::ST_EMIT_REST;
            end
            mkvlace_pkg::ST_EMIT_LACE:
            begin
                if (can_load)
                begin
                    ov_next     = 1'b1;
                    otrack_next = track_reg;
                    opts_next   = pts_reg;
                    okey_next   = flags_reg[7];
                    if (neg_reg)
                    begin
                        osize_next = '0;
                    end
                    else if (|lx_reg[63:32])
                    begin
                        osize_next = mkvlace_pkg::SIZE_MAX;
                    end
                    else
                    begin
                        osize_next = lx_reg[31:0];
                    end
                    orep_next  = 9'd1;
                    ohdr_next  = '0;
                    olast_next = 1'b0;
                    ostat_next = over_reg;
                    laces_next = laces_dec;
                    state_next = (laces_dec == 8'd0) ? mkvlace_pkg::ST_EMIT_REST
                                                     : mkvlace_pkg::ST_READY;
                end
            end
            mkvlace_pkg::ST_EMIT_REST:
            begin
                if (can_load)
                begin
                    ov_next     = 1'b1;
                    otrack_next = track_reg;
                    opts_next   = pts_reg;
                    okey_next   = flags_reg[7];
                    osize_next  = over_reg ? 32'd0 : rest_reg;
                    orep_next   = 9'd1;
                    ohdr_next   = hcnt_reg;
                    olast_next  = 1'b1;
                    ostat_next  = over_reg;
                    phase_next  = mkvlace_pkg::PH_IDLE;
                    state_next  = mkvlace_pkg::ST_READY;
                end
            end
            mkvlace_pkg::ST_FSUB:
            begin
                if (!alu_cout)
                begin
                    fbad_next  = 1'b1;
                    quot_next  = '0;
                    state_next = mkvlace_pkg::ST_EMIT_FIX;
                end
                else
                begin
                    fbad_next  = 1'b0;
                    quot_next  = alu_sum[31:0];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = mkvlace_pkg::ST_DIV;
                end
            end
            mkvlace_pkg::ST_DIV:
            begin
                // One restoring step: the quotient bit is the carry of the trial subtract.
                rem_next  = alu_cout ? alu_sum[7:0] : {rem_reg[6:0], quot_reg[31]};
                quot_next = {quot_reg[30:0], alu_cout};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = mkvlace_pkg::ST_EMIT_FIX;
                end
            end
            mkvlace_pkg::ST_EMIT_FIX:
            begin
                if (can_load)
                begin
                    ov_next     = 1'b1;
                    otrack_next = track_reg;
                    opts_next   = pts_reg;
                    okey_next   = flags_reg[7];
                    osize_next  = quot_reg;
                    orep_next   = rep_reg;
                    ohdr_next   = hcnt_reg;
                    olast_next  = 1'b1;
                    ostat_next  = fbad_reg;
                    phase_next  = mkvlace_pkg::PH_IDLE;
                    state_next  = mkvlace_pkg::ST_READY;
                end
            end
            default:
            begin
                state_next = mkvlace_pkg::ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mkvlace_pkg::ST_READY;
            phase_reg  <= mkvlace_pkg::PH_IDLE;
            vacc_reg   <= '0;
            vleft_reg  <= '0;
            vlen_reg   <= '0;
            track_reg  <= '0;
            pts_reg    <= '0;
            flags_reg  <= '0;
            bsize_reg  <= '0;
            laces_reg  <= '0;
            lacc_reg   <= '0;
            lsum_reg   <= '0;
            hcnt_reg   <= '0;
            lpath_reg  <= 1'b0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            vacc_reg   <= vacc_next;
            vleft_reg  <= vleft_next;
            vlen_reg   <= vlen_next;
            track_reg  <= track_next;
            pts_reg    <= pts_next;
            flags_reg  <= flags_next;
            bsize_reg  <= bsize_next;
            laces_reg  <= laces_next;
            lacc_reg   <= lacc_next;
            lsum_reg   <= lsum_next;
            hcnt_reg   <= hcnt_next;
            lpath_reg  <= lpath_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg      <= b_next;
        tmp_reg    <= tmp_next;
        lx_reg     <= lx_next;
        neg_reg    <= neg_next;
        over_reg   <= over_next;
        rest_reg   <= rest_next;
        rep_reg    <= rep_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        fbad_reg   <= fbad_next;
        osize_reg  <= osize_next;
        orep_reg   <= orep_next;
        ohdr_reg   <= ohdr_next;
        olast_reg  <= olast_next;
        ostat_reg  <= ostat_next;
        otrack_reg <= otrack_next;
        opts_reg   <= opts_next;
        okey_reg   <= okey_next;
    end

    assign out_valid    = ov_reg;
    assign track_number = otrack_reg;
    assign pts          = opts_reg;
    assign keyframe     = okey_reg;
    assign frame_size   = osize_reg;
    assign repeat_count = orep_reg;
    assign header_size  = ohdr_reg;
    assign last_lace    = olast_reg;
    assign status       = ostat_reg;

    `ASSERT_PROP(a_state_onehot, clk, rst_n, $onehot(state_reg))
    `ASSERT_PROP(a_mid_record, clk, rst_n,
        (out_valid && !last_lace) |-> (header_size == 16'd0 && repeat_count == 9'd1))
    `ASSERT_NEVER(a_div_count_idle, clk, rst_n, (state_reg != mkvlace_pkg::ST_DIV) && (cnt_reg != 5'd0))

endmodule

>>> tb/sv/matroska_block_lace_checker.sv
// Predicts the frame records of the block lace parser and compares them with its output.
module matroska_block_lace_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               block_start,
    input  logic [31:0]        block_size,
    input  logic               is_simple,
    input  logic [47:0]        cluster_timecode,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [55:0]        track_number,
    input  logic signed [49:0] pts,
    input  logic               keyframe,
    input  logic [31:0]        frame_size,
    input  logic [8:0]         repeat_count,
    input  logic [15:0]        header_size,
    input  logic               last_lace,
    input  logic               status,
    output int                 fail_count,
    output int                 pending_count
);

    localparam int VMAX = 8;
    localparam logic [63:0] CAP64 = 64'h100_0000_0000;

    typedef struct packed {
        logic [55:0] track;
        logic [49:0] pts;
        logic        key;
        logic [31:0] size;
        logic [8:0]  rep;
        logic [15:0] hdr;
        logic        last;
        logic        bad;
    } frame_rec_t;

    frame_rec_t expected_frames[$];

    mkvlace_pkg::phase_t phase;
    logic [63:0] vacc;
    int unsigned vleft, vlen;
    logic [55:0] trk;
    logic [49:0] pts_s;
    logic [7:0]  flags;
    logic [63:0] bsize;
    logic [7:0]  laces;
    logic [63:0] lacc, lsum;
    logic [15:0] hcount;

    function automatic void clear_state();
        phase = mkvlace_pkg::PH_IDLE; vacc = '0; vleft = 0; vlen = 0; trk = '0; pts_s = '0;
        flags = '0; bsize = '0; laces = '0; lacc = '0; lsum = '0; hcount = '0;
    endfunction

    function automatic bit vint_feed(logic [7:0] b);
        int unsigned len;
        if (vleft == 0) begin
            len = 1;
            while (len <= 8 && b[8 - len] == 1'b0)
                len++;
            if (len > VMAX) begin
                len = VMAX;
                vacc = '0;
            end
            else
                vacc = 64'(b & (8'hFF >> len));
            vlen = len;
            vleft = len - 1;
        end
        else begin
            vacc = (vacc << 8) | 64'(b);
            vleft--;
        end
        return vleft == 0;
    endfunction

    function automatic bit overrun();
        return 64'(hcount) + lsum > bsize;
    endfunction

    function automatic void push_frame(logic [63:0] sz, logic [8:0] rep, bit last, bit bad);
        frame_rec_t r;
        r.track = trk;
        r.pts = pts_s;
        r.key = flags[7];
        r.size = (sz > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sz[31:0];
        r.rep = rep;
        r.hdr = last ? hcount : 16'd0;
        r.last = last;
        r.bad = bad;
        expected_frames.push_back(r);
    endfunction

    function automatic void push_remainder();
        if (overrun())
            push_frame(64'd0, 9'd1, 1'b1, 1'b1);
        else
            push_frame(bsize - 64'(hcount) - lsum, 9'd1, 1'b1, 1'b0);
        phase = mkvlace_pkg::PH_IDLE;
    endfunction

    function automatic void push_lace(logic [63:0] sz, bit neg);
        logic [63:0] x;
        x = neg ? CAP64 : sz;
        if (x >= CAP64 || lsum + x >= CAP64)
            lsum = CAP64;
        else
            lsum = lsum + x;
        push_frame(neg ? 64'd0 : sz, 9'd1, 1'b0, overrun());
        laces = laces - 8'd1;
        if (laces == 8'd0)
            push_remainder();
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic bs, logic [31:0] bsz,
                                         logic simp, logic [47:0] ctc);
        logic [63:0] tc, shift;
        logic [1:0] mode;
        logic [8:0] rep;
        if (bs) begin
            clear_state();
            phase = mkvlace_pkg::PH_TRACK;
            bsize = 64'(bsz);
            flags = {simp, 7'd0};
            pts_s = 50'(ctc);
        end
        if (phase == mkvlace_pkg::PH_IDLE)
            return;
        if (hcount != mkvlace_pkg::HDR_MAX)
            hcount++;
        case (phase)
            mkvlace_pkg::PH_TRACK:
                if (vint_feed(b)) begin
                    trk = vacc[55:0];
                    phase = mkvlace_pkg::PH_TC_HI;
                end
            mkvlace_pkg::PH_TC_HI: begin
                vacc = 64'(b);
                phase = mkvlace_pkg::PH_TC_LO;
            end
            mkvlace_pkg::PH_TC_LO: begin
                tc = 64'(signed'({vacc[7:0], b}));
                pts_s = pts_s + tc[49:0];
                phase = mkvlace_pkg::PH_FLAGS;
            end
            mkvlace_pkg::PH_FLAGS: begin
                flags = b & (8'h7F | flags);
                if (b[2:1] == mkvlace_pkg::LACE_NONE)
                    push_remainder();
                else
                    phase = mkvlace_pkg::PH_COUNT;
            end
            mkvlace_pkg::PH_COUNT: begin
                mode = flags[2:1];
                laces = b;
                lacc = '0;
                if (mode == mkvlace_pkg::LACE_FIXED) begin
                    rep = 9'(b) + 9'd1;
                    if (64'(hcount) > bsize)
                        push_frame(64'd0, rep, 1'b1, 1'b1);
                    else
                        push_frame((bsize - 64'(hcount)) / 64'(rep), rep, 1'b1, 1'b0);
                    phase = mkvlace_pkg::PH_IDLE;
                end
                else if (b == 8'd0)
                    push_remainder();
                else
                    phase = (mode == mkvlace_pkg::LACE_XIPH) ? mkvlace_pkg::PH_XIPH
                                                            : mkvlace_pkg::PH_EBML_FIRST;
            end
            mkvlace_pkg::PH_XIPH: begin
                if (lacc + 64'(b) >= CAP64)
                    lacc = CAP64;
                else
                    lacc = lacc + 64'(b);
                if (b != mkvlace_pkg::XIPH_RUN) begin
                    tc = lacc;
                    lacc = '0;
                    push_lace(tc, 1'b0);
                end
            end
            mkvlace_pkg::PH_EBML_FIRST:
                if (vint_feed(b)) begin
                    lacc = vacc;
                    phase = mkvlace_pkg::PH_EBML_DELTA;
                    push_lace(lacc, 1'b0);
                end
            mkvlace_pkg::PH_EBML_DELTA:
                if (vint_feed(b)) begin
                    shift = (64'd1 << (7 * vlen - 1)) - 64'd1;
                    lacc = lacc + vacc - shift;
                    push_lace(lacc, lacc[63]);
                end
            default: phase = mkvlace_pkg::PH_IDLE;
        endcase
    endfunction

    initial clear_state();

    always @(posedge clk or negedge rst_n) begin
        frame_rec_t e;
        if (!rst_n) begin
            fail_count <= 0;
            expected_frames.delete();
            clear_state();
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("frame record with none expected");
                    fail_count <= fail_count + 1;
                end
                else begin
                    e = expected_frames.pop_front();
                    if ({e.track, e.pts, e.key, e.size, e.rep, e.hdr, e.last, e.bad} !==
                        {track_number, pts, keyframe, frame_size, repeat_count,
                         header_size, last_lace, status}) begin
                        fail_count <= fail_count + 1;
                        if (e.track !== track_number)
                            $error("track_number exp %0h got %0h", e.track, track_number);
                        if (e.pts !== pts)
                            $error("pts exp %0h got %0h", e.pts, pts);
                        if (e.key !== keyframe)
                            $error("keyframe exp %0b got %0b", e.key, keyframe);
                        if (e.size !== frame_size)
                            $error("frame_size exp %0h got %0h", e.size, frame_size);
                        if (e.rep !== repeat_count)
                            $error("repeat_count exp %0d got %0d", e.rep, repeat_count);
                        if (e.hdr !== header_size)
                            $error("header_size exp %0d got %0d", e.hdr, header_size);
                        if (e.last !== last_lace)
                            $error("last_lace exp %0b got %0b", e.last, last_lace);
                        if (e.bad !== status)
                            $error("status exp %0b got %0b", e.bad, status);
                    end
                end
            end
            // Requests are predicted after the pop so a same-cycle record is not confused.
            if (in_valid && !in_stall)
                predict_byte(data_byte, block_start, block_size, is_simple, cluster_timecode);
        end
    end

    assign pending_count = expected_frames.size();
endmodule

>>> tb/sv/tb_matroska_block_lace_parser.sv
// Stimulus and verdict for the Matroska block lace parser.
module tb_matroska_block_lace_parser;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = '0;
    logic               block_start = 1'b0;
    logic [31:0]        block_size = '0;
    logic               is_simple = 1'b0;
    logic [47:0]        cluster_timecode = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [55:0]        track_number;
    logic signed [49:0] pts;
    logic               keyframe;
    logic [31:0]        frame_size;
    logic [8:0]         repeat_count;
    logic [15:0]        header_size;
    logic               last_lace;
    logic               status;
    int                 fail_count, pending_count;
    int                 cycle_count = 0;
    int                 sent = 0;
    logic [7:0]         block_bytes[$];

    localparam int CYCLE_LIMIT = 2_000_000;

    always #1 clk = ~clk;

    matroska_block_lace_parser dut (.*);

    matroska_block_lace_checker checker_i (.*);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int short_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(5, 30);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Receiver stall: alternates between busy stretches and stretches with no stalls.
    logic calm = 1'b0;
    always @(posedge clk) begin
        if ($urandom_range(0, 199) == 0)
            calm <= ~calm;
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 9) < 3 ||
                     ($urandom_range(0, 49) == 0));
    end

    task automatic send_byte(logic [7:0] b, logic first, logic [31:0] bsz, logic simp,
                             logic [47:0] ctc);
        int g;
        g = calm ? 0 : short_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        block_start <= first;
        block_size <= first ? bsz : 32'($urandom);
        is_simple <= first ? simp : 1'($urandom);
        cluster_timecode <= first ? ctc : {16'($urandom), 32'($urandom)};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Sends the bytes queued in block_bytes as one block.
    task automatic send_block(logic [31:0] bsz, logic simp, logic [47:0] ctc);
        for (int i = 0; i < block_bytes.size(); i++)
            send_byte(block_bytes[i], i == 0, bsz, simp, ctc);
        block_bytes.delete();
    endtask

    task automatic put_vint(int len, logic [63:0] v);
        logic [63:0] w;
        w = v | (64'h80 << (8 * (len - 1) - (len - 1)));
        for (int i = len - 1; i >= 0; i--)
            block_bytes.push_back(w[8 * i +: 8]);
    endtask

    task automatic put_header(logic [1:0] mode, logic key);
        int tl;
        tl = $urandom_range(0, 9) == 0 ? $urandom_range(1, 8) : $urandom_range(1, 2);
        put_vint(tl, {$urandom, $urandom} & ((64'd1 << (7 * tl)) - 1));
        block_bytes.push_back(8'($urandom));
        block_bytes.push_back(8'($urandom));
        block_bytes.push_back({key, 4'($urandom), mode, 1'($urandom)});
    endtask

    task automatic random_block();
        logic [1:0] mode;
        int n, pick;
        logic [31:0] bsz;
        mode = 2'($urandom);
        put_header(mode, 1'($urandom));
        if (mode != mkvlace_pkg::LACE_NONE) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 4);
            block_bytes.push_back(8'(n));
            if (mode == mkvlace_pkg::LACE_XIPH)
                for (int k = 0; k < n; k++) begin
                    repeat ($urandom_range(0, 2)) block_bytes.push_back(mkvlace_pkg::XIPH_RUN);
                    block_bytes.push_back(8'($urandom_range(0, 254)));
                end
            else if (mode == mkvlace_pkg::LACE_EBML)
                for (int k = 0; k < n; k++)
                    put_vint($urandom_range(1, 3), 64'($urandom_range(0, 400)) +
                             (k > 0 ? 64'd40 : 64'd0));
        end
        pick = $urandom_range(0, 9);
        bsz = pick == 0 ? $urandom : pick == 1 ? $urandom_range(0, 8)
                                   : $urandom_range(10, 3000);
        // Occasionally cut the block short, or tack on payload bytes that are ignored.
        if ($urandom_range(0, 14) == 0 && block_bytes.size() > 2)
            block_bytes = block_bytes[0:$urandom_range(0, block_bytes.size() - 2)];
        else if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) block_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 19) == 0 && block_bytes.size() > 0)
            block_bytes[$urandom_range(0, block_bytes.size() - 1)] = 8'($urandom);
        send_block(bsz, 1'($urandom), {16'($urandom), 32'($urandom)});
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Bytes before any block are ignored.
        send_byte(8'hFF, 1'b0, 32'd0, 1'b0, 48'd0);
        // No lacing, all-ones fields, negative timecode, keyframe.
        block_bytes = '{8'h81, 8'h80, 8'h00, 8'h80};
        send_block(32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF);
        // Invalid vint lead byte, zero size so the header overruns.
        block_bytes = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                        8'h7F, 8'hFF, 8'h7F};
        send_block(32'd0, 1'b0, 48'd0);
        // Xiph with runs of 255.
        block_bytes = '{8'h82, 8'h00, 8'h05, 8'h02, 8'h02, 8'hFF, 8'hFF, 8'h03, 8'h00};
        send_block(32'd1000, 1'b1, 48'h1234);
        // Fixed lacing with 256 frames, and with count zero.
        block_bytes = '{8'h81, 8'h00, 8'h00, 8'h84, 8'hFF};
        send_block(32'hFFFF_FFFF, 1'b0, 48'd0);
        block_bytes = '{8'h81, 8'h00, 8'h00, 8'h84, 8'h00};
        send_block(32'd3, 1'b0, 48'd0);
        // EBML lacing: zero count, then a negative delta, then an 8-byte size.
        block_bytes = '{8'h81, 8'h00, 8'h00, 8'h86, 8'h00};
        send_block(32'd50, 1'b1, 48'd7);
        block_bytes = '{8'h81, 8'h00, 8'h00, 8'h06, 8'h02, 8'h8A, 8'h81};
        send_block(32'd100, 1'b0, 48'd0);
        block_bytes = '{8'h81, 8'h00, 8'h00, 8'h06, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF,
                        8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_block(32'd100, 1'b0, 48'd0);
        // Block start in the middle of a header.
        block_bytes = '{8'h81, 8'h12};
        send_block(32'd20, 1'b0, 48'd0);
        // Hold off until every record has come back.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        while (sent < 1650)
            random_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/mkvlace_pkg.sv
sv/matroska_block_lace_parser.sv
tb/sv/matroska_block_lace_checker.sv
tb/sv/tb_matroska_block_lace_parser.sv
